// ===== hw/rtl/fpp_pkg.sv =====
// shared types, constants and helpers for the fen position parser
`timescale 1ns / 1ps

package fpp_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] EMPTY_PIECE   = 4'd12;
    localparam logic [6:0] BOARD_SQUARES = 7'd64;

    localparam logic [1:0] ST_ERROR   = 2'd0;
    localparam logic [1:0] ST_DIAGRAM = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic ACT_CHAR    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [2:0] {
        PH_BOARD   = 3'd0,
        PH_SIDE    = 3'd1,
        PH_SKIP_A  = 3'd2,
        PH_CASTLE  = 3'd3,
        PH_SKIP_B  = 3'd4,
        PH_PASSANT = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] character;
    } t_req;

    typedef struct packed {
        logic       kind;
        logic [5:0] square;
        logic [3:0] piece;
        logic [1:0] status;
        logic       black_to_move;
        logic       white_kingside;
        logic       white_queenside;
        logic       black_kingside;
        logic       black_queenside;
        logic       passant_given;
        logic [2:0] passant_file;
        logic       last;
    } t_res;

    // one queued job: a run of squares or one status result
    typedef struct packed {
        logic       is_status;
        logic [5:0] square;
        logic [2:0] run_last;
        logic [3:0] piece;
        logic [1:0] status;
        logic       black;
        logic [3:0] castle;
        logic       pgiven;
        logic [2:0] pfile;
    } t_cmd;

    // {found, index} of a piece letter in KkPQRBNpqrbn
    function automatic logic [4:0] piece_lookup(input logic [7:0] c);
        logic [4:0] r;
        case (c)
            "K":     r = {1'b1, 4'd0};
            "k":     r = {1'b1, 4'd1};
            "P":     r = {1'b1, 4'd2};
            "Q":     r = {1'b1, 4'd3};
            "R":     r = {1'b1, 4'd4};
            "B":     r = {1'b1, 4'd5};
            "N":     r = {1'b1, 4'd6};
            "p":     r = {1'b1, 4'd7};
            "q":     r = {1'b1, 4'd8};
            "r":     r = {1'b1, 4'd9};
            "b":     r = {1'b1, 4'd10};
            "n":     r = {1'b1, 4'd11};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/fpp_front.sv =====
// front end: parses one character per cycle while the job queue has room and queues result jobs
`timescale 1ns / 1ps

module fpp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fpp_pkg::t_req i_req,
    input  logic          i_q_full,
    output logic          o_push,
    output fpp_pkg::t_cmd o_cmd
);
    import fpp_pkg::*;

    t_phase     r_phase, n_phase;
    logic [6:0] r_filled, n_filled;
    logic [2:0] r_seen, n_seen;
    logic       r_side, n_side;
    logic [3:0] r_castle, n_castle;

    logic       take;
    logic       emit;
    t_cmd       cmd;
    logic [7:0] c;
    logic [3:0] digit;
    logic [7:0] digit_end;
    logic [4:0] pl;
    logic       white;

    assign o_ready   = !i_q_full;
    assign take      = i_valid && !i_q_full;
    assign c         = i_req.character;
    assign digit     = c[3:0];
    assign digit_end = {1'b0, r_filled} + {4'd0, digit};
    assign pl        = piece_lookup(c);
    assign white     = (c inside {[8'h09:8'h0D], 8'h20});

    always_comb begin
        n_phase  = r_phase;
        n_filled = r_filled;
        n_seen   = r_seen;
        n_side   = r_side;
        n_castle = r_castle;
        emit     = 1'b0;
        cmd      = '0;

        if (i_req.action == ACT_RESTART) begin
            n_phase  = PH_BOARD;
            n_filled = '0;
            n_seen   = '0;
            n_side   = 1'b0;
            n_castle = '0;
        end else begin
            case (r_phase)
                PH_BOARD: begin
                    if (white || c == 8'h00) begin
                        if (r_filled != BOARD_SQUARES) begin
                            emit = 1'b1;
                            cmd.is_status = 1'b1;
                            cmd.status    = ST_ERROR;
                        end else if (c inside {8'h00, 8'h0A, 8'h0D}) begin
                            emit = 1'b1;
                            cmd.is_status = 1'b1;
                            cmd.status    = ST_DIAGRAM;
                        end else begin
                            n_phase = PH_SIDE;
                        end
                    end else if (r_filled >= BOARD_SQUARES) begin
                        emit = 1'b1;
                        cmd.is_status = 1'b1;
                        cmd.status    = ST_ERROR;
                    end else if (c == "/") begin
                        // rank separator, nothing to emit
                    end else if (c inside {["1":"8"]}) begin
                        emit = 1'b1;
                        if (digit_end > {1'b0, BOARD_SQUARES}) begin
                            cmd.is_status = 1'b1;
                            cmd.status    = ST_ERROR;
                        end else begin
                            cmd.square   = r_filled[5:0];
                            cmd.run_last = 3'(digit - 4'd1);
                            cmd.piece    = EMPTY_PIECE;
                            n_filled     = digit_end[6:0];
                        end
                    end else if (pl[4]) begin
                        emit         = 1'b1;
                        cmd.square   = r_filled[5:0];
                        cmd.piece    = pl[3:0];
                        n_filled     = r_filled + 7'd1;
                    end else begin
                        emit = 1'b1;
                        cmd.is_status = 1'b1;
                        cmd.status    = ST_ERROR;
                    end
                end
                PH_SIDE: begin
                    if (c == "w") begin
                        n_side  = 1'b0;
                        n_phase = PH_SKIP_A;
                    end else if (c == "b") begin
                        n_side  = 1'b1;
                        n_phase = PH_SKIP_A;
                    end else begin
                        emit = 1'b1;
                        cmd.is_status = 1'b1;
                        cmd.status    = ST_ERROR;
                    end
                end
                PH_SKIP_A: n_phase = PH_CASTLE;
                PH_CASTLE: begin
                    if (c inside {"K", "Q", "k", "q", "-"}) begin
                        if (c == "K") n_castle[0] = 1'b1;
                        if (c == "Q") n_castle[1] = 1'b1;
                        if (c == "k") n_castle[2] = 1'b1;
                        if (c == "q") n_castle[3] = 1'b1;
                        n_seen = r_seen + 3'd1;
                        if (n_seen >= 3'd4) n_phase = PH_SKIP_B;
                    end else begin
                        n_phase = PH_PASSANT;
                    end
                end
                PH_SKIP_B: n_phase = PH_PASSANT;
                PH_PASSANT: begin
                    emit = 1'b1;
                    cmd.is_status = 1'b1;
                    if (c == "-" || (c >= "a" && c <= "h")) begin
                        cmd.status = ST_FULL;
                        cmd.black  = r_side;
                        cmd.castle = r_castle;
                        cmd.pgiven = (c != "-");
                        cmd.pfile  = (c == "-") ? 3'd0 : 3'(c - "a");
                    end else begin
                        cmd.status = ST_ERROR;
                    end
                end
                PH_DONE: begin
                    // ignore until restart
                end
                default: begin
                end
            endcase
            if (emit && cmd.is_status) n_phase = PH_DONE;
        end
    end

    assign o_push = take && emit;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BOARD;
            r_filled <= '0;
            r_seen   <= '0;
            r_side   <= 1'b0;
            r_castle <= '0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_filled <= n_filled;
            r_seen   <= n_seen;
            r_side   <= n_side;
            r_castle <= n_castle;
        end
    end

endmodule

// ===== hw/rtl/fpp_queue.sv =====
// short job queue between the front end and the result generator
`timescale 1ns / 1ps

module fpp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fpp_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output fpp_pkg::t_cmd o_cmd
);
    import fpp_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr, r_rptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push, do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/fpp_back.sv =====
// back end: expands queued jobs into results, one per cycle unless stalled, into an output register
`timescale 1ns / 1ps

module fpp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  fpp_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output fpp_pkg::t_res o_res
);
    import fpp_pkg::*;

    logic [2:0] r_idx;
    logic       r_valid;
    t_res       r_res, n_res;
    logic       load, fire, run_end;

    assign load    = !r_valid || i_ready;
    assign fire    = load && i_q_valid;
    assign run_end = i_q_cmd.is_status || (r_idx == i_q_cmd.run_last);
    assign o_q_pop = fire && run_end;

    always_comb begin
        n_res = '0;
        n_res.last = run_end;
        if (i_q_cmd.is_status) begin
            n_res.kind            = 1'b1;
            n_res.status          = i_q_cmd.status;
            n_res.black_to_move   = i_q_cmd.black;
            n_res.white_kingside  = i_q_cmd.castle[0];
            n_res.white_queenside = i_q_cmd.castle[1];
            n_res.black_kingside  = i_q_cmd.castle[2];
            n_res.black_queenside = i_q_cmd.castle[3];
            n_res.passant_given   = i_q_cmd.pgiven;
            n_res.passant_file    = i_q_cmd.pfile;
        end else begin
            n_res.square = i_q_cmd.square + {3'd0, r_idx};
            n_res.piece  = i_q_cmd.piece;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) r_valid <= i_q_valid;
            if (fire) r_idx <= run_end ? 3'd0 : r_idx + 3'd1;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hw/rtl/fen_position_parser.sv =====
// top level of the streaming fen position parser
`timescale 1ns / 1ps

// usage:
//   request channel (i_req_valid / o_req_ready / i_req) carries one character of
//   the position string, or a restart, per request
//   result channel (o_res_valid / i_res_ready / o_res) carries square results
//   and one final status result; last marks the final result of a request
// first result: a request that gives results has its job written into the queue,
//   then its first result registered in the output register, when both are empty
// throughput: the front end takes one request per cycle while the job queue
//   (two entries) has room; the back end emits one result per cycle unless
//   stalled, a digit n gives n results, and a digit run stalls requests once
//   the queue fills; slashes, restarts and field characters emit nothing
// reset: synchronous active-low i_rst_n empties the queue and output register
//   and puts the parser in the board field with no squares filled
// stall: if i_res_ready is low the output register holds its result, the
//   back end stops draining, and o_req_ready drops once the queue is full
// characters after the final status result are dropped until a restart

module fen_position_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  fpp_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output fpp_pkg::t_res o_res
);
    import fpp_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    t_cmd push_cmd, head_cmd;

    // character decode and parse state
    fpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_ready (o_req_ready),
        .i_req   (i_req),
        .i_q_full(q_full),
        .o_push  (q_push),
        .o_cmd   (push_cmd)
    );

    // job queue decoupling parse from result generation
    fpp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (push_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (head_cmd)
    );

    // result generator with registered output
    fpp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_cmd  (head_cmd),
        .o_q_pop  (q_pop),
        .o_valid  (o_res_valid),
        .i_ready  (i_res_ready),
        .o_res    (o_res)
    );

endmodule
